/* sv/spq_pkg.sv */
// Package: shared codes, widths and control types of the sorted priority queue.
package spq_pkg;

   // Defaults of the top-level parameters
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_PRIO_BITS   = 8;
   localparam int DEF_HANDLE_BITS = 16;

   // Fixed field widths
   localparam int FUNC_BITS   = 1;
   localparam int STATUS_BITS = 2;
   localparam int OCC_BITS    = 5;

   // Operation codes
   localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 1'b0;
   localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 1'b1;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic rem;
   } spq_ctl_type;

endpackage

/* sv/spq_cell.sv */
// Module: one storage cell of the sorted shift chain.
module spq_cell
   import spq_pkg::*;
#(
   parameter int PRIO_BITS   = DEF_PRIO_BITS,
   parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_ctl_type            ctl,
   input  logic [PRIO_BITS-1:0]   new_prio,
   input  logic [HANDLE_BITS-1:0] new_handle,
   input  logic                   left_valid,
   input  logic [PRIO_BITS-1:0]   left_prio,
   input  logic [HANDLE_BITS-1:0] left_handle,
   input  logic                   left_gt,
   input  logic                   right_valid,
   input  logic [PRIO_BITS-1:0]   right_prio,
   input  logic [HANDLE_BITS-1:0] right_handle,
   output logic                   valid,
   output logic [PRIO_BITS-1:0]   prio,
   output logic [HANDLE_BITS-1:0] handle,
   output logic                   gt
);

   logic                   valid_ff, valid_in;
   logic [PRIO_BITS-1:0]   prio_ff, prio_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;

   // empty cells count as holding an infinitely large priority
   assign gt = !valid_ff || (prio_ff > new_prio);

   always_comb begin
      valid_in  = valid_ff;
      prio_in   = prio_ff;
      handle_in = handle_ff;
      if (ctl.rem) begin
         valid_in  = right_valid;
         prio_in   = right_prio;
         handle_in = right_handle;
      end else if (ctl.ins && gt) begin
         if (left_gt) begin
            // make room: take the neighbor's entry
            valid_in  = left_valid;
            prio_in   = left_prio;
            handle_in = left_handle;
         end else begin
            valid_in  = 1'b1;
            prio_in   = new_prio;
            handle_in = new_handle;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prio_ff   <= prio_in;
      handle_ff <= handle_in;
   end

   assign valid  = valid_ff;
   assign prio   = prio_ff;
   assign handle = handle_ff;

endmodule

/* sv/sorted_priority_queue_core.sv */
// Module: top level of the sorted priority queue built as a chain of cells.
//
// Usage:
//  - Request channel (req_*): req_func selects insert or remove; req_handle_in
//    and req_prio_in give the entry on insert. A transfer happens on a rising
//    edge with req_valid high and req_stall low.
//  - Response channel (rsp_*): exactly one response per request, in order:
//    rsp_status (ok, empty on remove, full on insert), rsp_handle_out (the
//    removed head handle, zero otherwise) and rsp_occupancy after the op.
//  - Response: registered, it shows in the cycle after the request transfer.
//  - Throughput: one request per cycle while req_stall is low. Every cell
//    compares its own priority with the incoming one and shifts in one step,
//    so an insert or a remove finishes in the cycle of its transfer.
//  - Lower priority values leave first; equal priorities leave in arrival
//    order. An insert into a full queue is dropped with status full.
//  - Stall: while rsp_stall holds a waiting response, req_stall is raised
//    and the queue state and response stay frozen. A new request is still
//    taken in the cycle the waiting response transfers.
//  - Reset (synchronous, active high) empties the queue at once; entry
//    payloads are not cleared, only the per-cell valid bits.
module sorted_priority_queue_core
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int PRIO_BITS   = DEF_PRIO_BITS,
   parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [FUNC_BITS-1:0]   req_func,
   input  logic [HANDLE_BITS-1:0] req_handle_in,
   input  logic [PRIO_BITS-1:0]   req_prio_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_handle_out,
   output logic [OCC_BITS-1:0]    rsp_occupancy
);

   localparam int                  CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [CNT_BITS-1:0] CNT_ONE   = CNT_BITS'(1);

   // chain taps: index i is cell i, cell 0 is the head
   logic                   cell_valid  [QUEUE_DEPTH];
   logic [PRIO_BITS-1:0]   cell_prio   [QUEUE_DEPTH];
   logic [HANDLE_BITS-1:0] cell_handle [QUEUE_DEPTH];
   logic                   cell_gt     [QUEUE_DEPTH];

   logic                   accept;
   logic                   is_insert;
   logic                   full;
   logic                   empty;
   spq_ctl_type            ctl;

   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [OCC_BITS-1:0]    occ_ff, occ_in;

   // response register parts the two sides; hold only while it is stuck
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_insert = (req_func == FUNC_INSERT);
   assign full      = (count_ff == DEPTH_CNT);
   assign empty     = (count_ff == '0);

   // full inserts and empty removes leave the chain untouched
   assign ctl.ins = accept && is_insert && !full;
   assign ctl.rem = accept && !is_insert && !empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                   l_valid, l_gt, r_valid;
      logic [PRIO_BITS-1:0]   l_prio, r_prio;
      logic [HANDLE_BITS-1:0] l_handle, r_handle;

      if (i == 0) begin : g_head
         assign l_valid  = 1'b0;
         assign l_gt     = 1'b0;
         assign l_prio   = '0;
         assign l_handle = '0;
      end else begin : g_mid
         assign l_valid  = cell_valid[i-1];
         assign l_gt     = cell_gt[i-1];
         assign l_prio   = cell_prio[i-1];
         assign l_handle = cell_handle[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign r_valid  = 1'b0;
         assign r_prio   = '0;
         assign r_handle = '0;
      end else begin : g_body
         assign r_valid  = cell_valid[i+1];
         assign r_prio   = cell_prio[i+1];
         assign r_handle = cell_handle[i+1];
      end

      spq_cell #(
         .PRIO_BITS   (PRIO_BITS),
         .HANDLE_BITS (HANDLE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .new_prio     (req_prio_in),
         .new_handle   (req_handle_in),
         .left_valid   (l_valid),
         .left_prio    (l_prio),
         .left_handle  (l_handle),
         .left_gt      (l_gt),
         .right_valid  (r_valid),
         .right_prio   (r_prio),
         .right_handle (r_handle),
         .valid        (cell_valid[i]),
         .prio         (cell_prio[i]),
         .handle       (cell_handle[i]),
         .gt           (cell_gt[i])
      );
   end

   // fill count and response build
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      handle_in    = handle_ff;
      occ_in       = occ_ff;
      if (ctl.ins) begin
         count_in = count_ff + CNT_ONE;
      end else if (ctl.rem) begin
         count_in = count_ff - CNT_ONE;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         handle_in    = '0;
         status_in    = ST_OK;
         if (is_insert && full) begin
            status_in = ST_FULL;
         end else if (!is_insert && empty) begin
            status_in = ST_EMPTY;
         end else if (!is_insert) begin
            handle_in = cell_handle[0];
         end
         occ_in = OCC_BITS'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      handle_ff <= handle_in;
      occ_ff    <= occ_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_handle_out = handle_ff;
   assign rsp_occupancy  = occ_ff;

endmodule

/* sv/spq_checker.sv */
// Module: port-level checker for the sorted priority queue, with its bind.
module spq_checker
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [STATUS_BITS-1:0] rsp_status,
   input logic [HANDLE_BITS-1:0] rsp_handle_out,
   input logic [OCC_BITS-1:0]    rsp_occupancy
);

   localparam logic [OCC_BITS-1:0] DEPTH_OCC = OCC_BITS'(QUEUE_DEPTH);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_handle_out) && $stable(rsp_occupancy))
      else $error("stalled response changed");

   // requests are held off only by a stuck response
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stuck response");

   // a full report leaves the queue at depth with no handle
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == DEPTH_OCC
         && rsp_handle_out == '0)
      else $error("full response inconsistent");

   // an empty report leaves the queue empty with no handle
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_occupancy == '0
         && rsp_handle_out == '0)
      else $error("empty response inconsistent");

   // a valid response carries one of the three known status codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_EMPTY
         || rsp_status == ST_FULL)
      else $error("unknown response status");

endmodule

bind sorted_priority_queue_core spq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH),
   .HANDLE_BITS (HANDLE_BITS)
) u_spq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_handle_out (rsp_handle_out),
   .rsp_occupancy  (rsp_occupancy)
);
